[sv/sbab_pkg.sv]
// sprite blit and alpha blend: shared types and constants
// word structs for the pixel, write and configuration paths, register indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbab_pkg;

    // signed width that holds every placed coordinate before the frame check
    localparam int COORD_W = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [8:0] ALPHA_ONE = 9'd256;

    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_X      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_Y      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_ALPHA   = 3'd7;

    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_CW   = 2'd1;
    localparam logic [1:0] ROT_CCW  = 2'd2;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic [7:0]  sprite_col;
        logic [7:0]  sprite_row;
    } pix_word_t;

    typedef struct packed {
        logic [14:0] frame_address;
        logic [15:0] written_color;
    } wr_word_t;

    typedef struct packed {
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
    } rgb565_t;

    typedef struct packed {
        logic signed [8:0] origin_x;
        logic signed [8:0] origin_y;
        logic [7:0]        sprite_width;
        logic [7:0]        sprite_height;
        logic              mirror_x;
        logic              mirror_y;
        logic [1:0]        rotation;
        logic [8:0]        blend_alpha;
    } cfg_t;

endpackage

`default_nettype wire

[sv/sbab_front.sv]
// front end: takes sprite pixel words, places them in the frame, drops
// transparent and off-frame pixels, forms the store address; uses sbab_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbab_front
    import sbab_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 160,
    parameter int ADDR_W       = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              busy,
    input  wire logic              pix_valid,
    output logic                   pix_stall,
    input  wire pix_word_t         pix_word,
    input  wire logic              q_full,
    output logic                   q_push,
    output logic [ADDR_W-1:0]      q_addr,
    output logic [15:0]            q_color
);

    localparam int X_W = $clog2(FRAME_WIDTH);
    localparam int Y_W = $clog2(FRAME_HEIGHT);

    logic                      f_valid_reg;
    logic                      f_valid_next;
    logic [X_W-1:0]            f_x_reg;
    logic [Y_W-1:0]            f_y_reg;
    logic [15:0]               f_color_reg;

    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] w_s;
    logic signed [COORD_W-1:0] h_s;
    logic signed [COORD_W-1:0] c_s;
    logic signed [COORD_W-1:0] r_s;
    logic signed [COORD_W-1:0] w_flip;
    logic signed [COORD_W-1:0] h_flip;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] x_s;
    logic signed [COORD_W-1:0] y_s;
    logic                      keep;
    logic                      accept;

    always_comb
    begin
        ox     = {{(COORD_W-9){cfg.origin_x[8]}}, cfg.origin_x};
        oy     = {{(COORD_W-9){cfg.origin_y[8]}}, cfg.origin_y};
        w_s    = {{(COORD_W-8){1'b0}}, cfg.sprite_width};
        h_s    = {{(COORD_W-8){1'b0}}, cfg.sprite_height};
        c_s    = {{(COORD_W-8){1'b0}}, pix_word.sprite_col};
        r_s    = {{(COORD_W-8){1'b0}}, pix_word.sprite_row};
        w_flip = w_s - COORD_W'(1) - c_s;
        h_flip = h_s - COORD_W'(1) - r_s;
        unique case (cfg.rotation)
            ROT_CW:
            begin
                dx = h_flip;
                dy = c_s;
            end
            ROT_CCW:
            begin
                dx = r_s;
                dy = w_flip;
            end
            default:
            begin
                // no rotation, and the unused fourth code, take the mirrors
                dx = cfg.mirror_x ? w_flip : c_s;
                dy = cfg.mirror_y ? h_flip : r_s;
            end
        endcase
        x_s  = ox + dx;
        y_s  = oy + dy;
        keep = (pix_word.pixel_color != 16'd0)
            && (x_s >= 0) && (x_s < FRAME_WIDTH)
            && (y_s >= 0) && (y_s < FRAME_HEIGHT);
    end

    assign pix_stall = busy || (f_valid_reg && q_full);
    assign accept    = pix_valid && !pix_stall;
    assign q_push    = f_valid_reg && !q_full;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = keep;
        end
        else if (q_push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_x_reg     <= x_s[X_W-1:0];
            f_y_reg     <= y_s[Y_W-1:0];
            f_color_reg <= pix_word.pixel_color;
        end
    end

    // column-major store: x times frame height plus y
    assign q_addr  = ADDR_W'(f_x_reg) * ADDR_W'(FRAME_HEIGHT) + ADDR_W'(f_y_reg);
    assign q_color = f_color_reg;

endmodule

`default_nettype wire

[sv/sbab_queue.sv]
// small first-in first-out queue between the front and back ends
// generic payload width; default depth from sbab_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbab_queue
    import sbab_pkg::*;
#(
    parameter int DATA_W = 31,
    parameter int DEPTH  = QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      rdata,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[sv/sbab_back.sv]
// back end: frame store with clearing pass, read-modify-write with forwarding,
// per-channel q8 blend and the output word register; uses sbab_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbab_back
    import sbab_pkg::*;
#(
    parameter int DEPTH  = 20480,
    parameter int ADDR_W = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [8:0]        blend_alpha,
    input  wire logic              q_empty,
    input  wire logic [ADDR_W-1:0] q_addr,
    input  wire logic [15:0]       q_color,
    output logic                   q_pop,
    output logic                   busy,
    output logic                   wr_valid,
    input  wire logic              wr_stall,
    output wr_word_t               wr_word
);

    logic [15:0]       frame_mem [DEPTH];

    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic              s2_valid_reg;
    logic              s2_valid_next;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [15:0]       s2_color_reg;
    logic [15:0]       rdata_reg;

    logic              lw_valid_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    logic [15:0]       lw_data_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    wr_word_t          out_word_reg;

    logic              fire;
    logic [8:0]        a_sat;
    logic [8:0]        a_inv;
    rgb565_t           old_px;
    rgb565_t           new_px;
    rgb565_t           res_px;
    logic [14:0]       sum_r;
    logic [14:0]       sum_g;
    logic [14:0]       sum_b;
    logic [31:0]       addr_wide;

    assign busy     = clearing_reg;
    assign fire     = s2_valid_reg && (!out_valid_reg || !wr_stall);
    assign q_pop    = !q_empty && (!s2_valid_reg || fire);
    assign wr_valid = out_valid_reg;
    assign wr_word  = out_word_reg;

    // forward the previous write, which can land on the same edge as this read
    always_comb
    begin
        a_sat  = (blend_alpha > ALPHA_ONE) ? ALPHA_ONE : blend_alpha;
        a_inv  = ALPHA_ONE - a_sat;
        old_px = (lw_valid_reg && lw_addr_reg == s2_addr_reg) ? lw_data_reg : rdata_reg;
        new_px = s2_color_reg;
        sum_r  = 15'(a_sat) * 15'(old_px.r) + 15'(a_inv) * 15'(new_px.r);
        sum_g  = 15'(a_sat) * 15'(old_px.g) + 15'(a_inv) * 15'(new_px.g);
        sum_b  = 15'(a_sat) * 15'(old_px.b) + 15'(a_inv) * 15'(new_px.b);
        res_px.r = sum_r[8 +: 5];
        res_px.g = sum_g[8 +: 6];
        res_px.b = sum_b[8 +: 5];
        addr_wide = 32'(s2_addr_reg);
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (q_pop)
        begin
            s2_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s2_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!wr_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                end
            end
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_addr_reg  <= q_addr;
            s2_color_reg <= q_color;
        end
        if (fire)
        begin
            lw_addr_reg                <= s2_addr_reg;
            lw_data_reg                <= res_px;
            out_word_reg.frame_address <= addr_wide[14:0];
            out_word_reg.written_color <= res_px;
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            frame_mem[clr_cnt_reg] <= 16'd0;
        end
        else if (fire)
        begin
            frame_mem[s2_addr_reg] <= res_px;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rdata_reg <= frame_mem[q_addr];
        end
    end

endmodule

`default_nettype wire

[sv/sprite_blit_alpha_blend_unit.sv]
// sprite blit and alpha blend unit: top level with configuration registers
// instantiates sbab_front, sbab_queue and sbab_back; uses sbab_pkg
//
// usage
//   pix channel: one word per sprite pixel (rgb565 color, sprite column and
//   row), taken at a rising edge with pix_valid high and pix_stall low
//   wr channel: one word per frame write (address, stored color), taken at a
//   rising edge with wr_valid high and wr_stall low; black pixels and pixels
//   landing outside the frame give no word
//   cfg channel: register index and data, written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high, write only while idle
//   throughput: one pixel word per cycle sustained while wr_stall stays low,
//   set by the single frame store port pair (one read and one write each
//   cycle) with the previous write forwarded into the blend
//   pipeline: from the accepting edge to wr_valid a word passes the placement
//   stage, the queue, the store read and blend, and the output register
//   reset: registers take their reset values, then a clearing pass zeroes
//   all FRAME_WIDTH * FRAME_HEIGHT store entries (20480 by default), one
//   entry a cycle; pix_stall stays high during it
//   receiver stall: the output word holds, the blend stage and the
//   4-word queue fill, then pix_stall rises; nothing is lost
`timescale 1ns / 1ps
`default_nettype none

module sprite_blit_alpha_blend_unit
    import sbab_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 160
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pix_valid,
    output logic                        pix_stall,
    input  wire pix_word_t              pix_word,
    output logic                        wr_valid,
    input  wire logic                   wr_stall,
    output wr_word_t                    wr_word,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    cfg_t              cfg_reg;

    logic              busy;
    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    logic [ADDR_W-1:0] push_addr;
    logic [15:0]       push_color;
    logic [ADDR_W-1:0] pop_addr;
    logic [15:0]       pop_color;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.sprite_width  <= 8'd1;
            cfg_reg.sprite_height <= 8'd1;
            cfg_reg.mirror_x      <= 1'b0;
            cfg_reg.mirror_y      <= 1'b0;
            cfg_reg.rotation      <= ROT_NONE;
            cfg_reg.blend_alpha   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_data;
                CFG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg_data;
                CFG_SPRITE_WIDTH:  cfg_reg.sprite_width  <= cfg_data[7:0];
                CFG_SPRITE_HEIGHT: cfg_reg.sprite_height <= cfg_data[7:0];
                CFG_MIRROR_X:      cfg_reg.mirror_x      <= cfg_data[0];
                CFG_MIRROR_Y:      cfg_reg.mirror_y      <= cfg_data[0];
                CFG_ROTATION:      cfg_reg.rotation      <= cfg_data[1:0];
                CFG_BLEND_ALPHA:   cfg_reg.blend_alpha   <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // front end: placement, mirror and rotation, clipping, address
    sbab_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .busy      (busy),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_addr    (push_addr),
        .q_color   (push_color)
    );

    // decoupling queue of store writes still to be done
    sbab_queue #(
        .DATA_W (ADDR_W + 16),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({push_addr, push_color}),
        .pop   (q_pop),
        .rdata ({pop_addr, pop_color}),
        .full  (q_full),
        .empty (q_empty)
    );

    // back end: frame store read-modify-write and blend
    sbab_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .blend_alpha (cfg_reg.blend_alpha),
        .q_empty     (q_empty),
        .q_addr      (pop_addr),
        .q_color     (pop_color),
        .q_pop       (q_pop),
        .busy        (busy),
        .wr_valid    (wr_valid),
        .wr_stall    (wr_stall),
        .wr_word     (wr_word)
    );

    // no write word can appear while the store is still being cleared
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !wr_valid)
        else $error("write word during clearing pass");

    // the front end never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("push into full queue");

    // the back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // addresses stay inside the frame unless the frame exceeds the address field
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid |-> ((DEPTH > 32768) || (32'(wr_word.frame_address) < DEPTH)))
        else $error("write address outside frame");

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for sprite_blit_alpha_blend_unit: placement, clipping, blend
// depends on sbab_pkg and the rtl of the unit; keeps its own shadow of the frame store
// directed table first, then random sprite phases under random idling on both sides
`timescale 1ns / 1ps

module testbench;
    import sbab_pkg::*;

    localparam int FRAME_W = 128;
    localparam int FRAME_H = 160;
    localparam int RANDOM_ITEMS = 400;
    // settling wait that outlasts the pipeline before touching registers
    localparam int SETTLE_CYCLES = 8;
    // clearing pass plus the slowest run, taken several times over
    localparam longint LIMIT_NS = 64'd4_800_000;
    // rotation code with no meaning of its own, behaves as no rotation
    localparam logic [1:0] ROT_SPARE = 2'd3;

    // one row of the directed table
    typedef struct {
        cfg_t      cfg;
        pix_word_t pix;
        bit        typed;      // expected write typed in by hand
        bit        typed_hit;  // typed row that gives a write at all
        wr_word_t  typed_word;
    } blit_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      pix_valid;
    logic      pix_stall;
    pix_word_t pix_word;
    logic      wr_valid;
    logic      wr_stall;
    wr_word_t  wr_word;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // shadow copy of the registers and the frame store
    cfg_t        model_cfg;
    logic [15:0] shadow_frame [0:FRAME_W*FRAME_H-1];
    // frame writes predicted but not yet seen on the wr channel
    wr_word_t    pending_writes [$];
    int          mismatch_count = 0;

    // receiver stall pattern state
    int rx_mode = 0;
    int rx_left = 0;

    sprite_blit_alpha_blend_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .wr_valid  (wr_valid),
        .wr_stall  (wr_stall),
        .wr_word   (wr_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    function automatic cfg_t mk_cfg(input int ox, input int oy, input int w, input int h,
                                    input bit mx, input bit my, input logic [1:0] rot,
                                    input int alpha);
        cfg_t c;
        c.origin_x      = 9'(ox);
        c.origin_y      = 9'(oy);
        c.sprite_width  = 8'(w);
        c.sprite_height = 8'(h);
        c.mirror_x      = mx;
        c.mirror_y      = my;
        c.rotation      = rot;
        c.blend_alpha   = 9'(alpha);
        return c;
    endfunction

    function automatic blit_row_t mk_row(input cfg_t c, input logic [15:0] color,
                                         input int col, input int rw, input bit typed,
                                         input bit hit, input int addr,
                                         input logic [15:0] wcol);
        blit_row_t t;
        t.cfg                      = c;
        t.pix.pixel_color          = color;
        t.pix.sprite_col           = 8'(col);
        t.pix.sprite_row           = 8'(rw);
        t.typed                    = typed;
        t.typed_hit                = hit;
        t.typed_word.frame_address = 15'(addr);
        t.typed_word.written_color = wcol;
        return t;
    endfunction

    // places one sprite pixel, clips it, blends it into the shadow frame
    // returns 1 with the frame write when the pixel lands
    function automatic bit predict_write(input pix_word_t p, output wr_word_t w);
        int      c, r, wd, ht, ox, oy, x, y, addr, a;
        rgb565_t old_px, new_px, res_px;
        c  = p.sprite_col;
        r  = p.sprite_row;
        wd = model_cfg.sprite_width;
        ht = model_cfg.sprite_height;
        ox = $signed(model_cfg.origin_x);
        oy = $signed(model_cfg.origin_y);
        w  = '0;
        // black is transparent
        if (p.pixel_color == 16'h0000)
            return 1'b0;
        case (model_cfg.rotation)
            ROT_CW:
            begin
                x = ox + ht - 1 - r;
                y = oy + c;
            end
            ROT_CCW:
            begin
                x = ox + r;
                y = oy + wd - 1 - c;
            end
            default:
            begin
                x = ox + (model_cfg.mirror_x ? wd - 1 - c : c);
                y = oy + (model_cfg.mirror_y ? ht - 1 - r : r);
            end
        endcase
        if (x < 0 || x >= FRAME_W || y < 0 || y >= FRAME_H)
            return 1'b0;
        addr = x * FRAME_H + y;
        a = (model_cfg.blend_alpha > ALPHA_ONE) ? int'(ALPHA_ONE) : int'(model_cfg.blend_alpha);
        new_px = p.pixel_color;
        if (a == 0)
            res_px = new_px;
        else
        begin
            old_px = shadow_frame[addr];
            res_px.r = 5'((a * old_px.r + (int'(ALPHA_ONE) - a) * new_px.r) >> 8);
            res_px.g = 6'((a * old_px.g + (int'(ALPHA_ONE) - a) * new_px.g) >> 8);
            res_px.b = 5'((a * old_px.b + (int'(ALPHA_ONE) - a) * new_px.b) >> 8);
        end
        shadow_frame[addr] = res_px;
        w.frame_address = addr[14:0];
        w.written_color = res_px;
        return 1'b1;
    endfunction

    // one register write; the shadow registers follow at the accepting edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ORIGIN_X:      model_cfg.origin_x      = data;
            CFG_ORIGIN_Y:      model_cfg.origin_y      = data;
            CFG_SPRITE_WIDTH:  model_cfg.sprite_width  = data[7:0];
            CFG_SPRITE_HEIGHT: model_cfg.sprite_height = data[7:0];
            CFG_MIRROR_X:      model_cfg.mirror_x      = data[0];
            CFG_MIRROR_Y:      model_cfg.mirror_y      = data[0];
            CFG_ROTATION:      model_cfg.rotation      = data[1:0];
            CFG_BLEND_ALPHA:   model_cfg.blend_alpha   = data;
        endcase
    endtask

    // writes all eight registers; unused upper data bits carry random junk
    task automatic program_regs(input cfg_t c);
        logic [8:0] junk;
        junk = 9'($urandom);
        write_reg(CFG_ORIGIN_X, c.origin_x);
        write_reg(CFG_ORIGIN_Y, c.origin_y);
        write_reg(CFG_SPRITE_WIDTH, {junk[8], c.sprite_width});
        write_reg(CFG_SPRITE_HEIGHT, {junk[7], c.sprite_height});
        write_reg(CFG_MIRROR_X, {junk[8:1], c.mirror_x});
        write_reg(CFG_MIRROR_Y, {junk[7:0], c.mirror_y});
        write_reg(CFG_ROTATION, {junk[6:0], c.rotation});
        write_reg(CFG_BLEND_ALPHA, c.blend_alpha);
        cfg_valid <= 1'b0;
    endtask

    // stop sending until every predicted write is out, then let dropped
    // pixels still in the pipe clear out
    task automatic drain_writes();
        pix_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // offers one pixel word and holds it until taken; valid stays high
    // so the next word can follow back to back
    task automatic send_pixel(input pix_word_t p, input bit typed, input bit typed_hit,
                              input wr_word_t typed_word);
        wr_word_t w;
        bit       hit;
        pix_valid <= 1'b1;
        pix_word  <= p;
        do
            @(posedge clk);
        while (pix_stall);
        // the predictor always runs so the shadow frame stays in step
        hit = predict_write(p, w);
        if (typed)
        begin
            hit = typed_hit;
            w   = typed_word;
        end
        if (hit)
            pending_writes.push_back(w);
    endtask

    // receiver: segments of free flow, random stall, solid stall, sparse stall
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(4, 40);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0:       wr_stall <= 1'b0;
            1:       wr_stall <= 1'($urandom_range(0, 1));
            2:       wr_stall <= 1'b1;
            default: wr_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // compare every accepted frame write with the oldest prediction
    always @(posedge clk)
    begin : watch_writes
        wr_word_t want;
        if (rst_n && wr_valid && !wr_stall)
        begin
            if (pending_writes.size() == 0)
                report_mismatch($sformatf("unexpected write addr %0d color %h",
                                          wr_word.frame_address, wr_word.written_color));
            else
            begin
                want = pending_writes.pop_front();
                if (wr_word.frame_address !== want.frame_address)
                    report_mismatch($sformatf("frame_address %0d, wanted %0d",
                                              wr_word.frame_address, want.frame_address));
                if (wr_word.written_color !== want.written_color)
                    report_mismatch($sformatf("written_color %h at %0d, wanted %h",
                                              wr_word.written_color, want.frame_address,
                                              want.written_color));
            end
        end
    end

    // watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        blit_row_t dir_rows [$];
        cfg_t      phase_cfg;
        pix_word_t p;
        int        counted, phase, phase_len, k, burst_left, idle_n;
        int        wd, ht, scan_c, scan_r, pick, spin;
        bit        scan_mode;

        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix_word  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        model_cfg = mk_cfg(0, 0, 1, 1, 1'b0, 1'b0, ROT_NONE, 0);
        for (int i = 0; i < FRAME_W * FRAME_H; i++)
            shadow_frame[i] = 16'h0000;

        // after reset: plain write, transparent black, white over it
        dir_rows.push_back(mk_row(mk_cfg(0, 0, 1, 1, 0, 0, ROT_NONE, 0),
                                  16'hF800, 0, 0, 1, 1, 0, 16'hF800));
        dir_rows.push_back(mk_row(mk_cfg(0, 0, 1, 1, 0, 0, ROT_NONE, 0),
                                  16'h0000, 0, 0, 1, 0, 0, 16'h0000));
        dir_rows.push_back(mk_row(mk_cfg(0, 0, 1, 1, 0, 0, ROT_NONE, 0),
                                  16'hFFFF, 0, 0, 1, 1, 0, 16'hFFFF));
        // last frame entry, then one step past the right and bottom edges
        dir_rows.push_back(mk_row(mk_cfg(127, 159, 1, 1, 0, 0, ROT_NONE, 0),
                                  16'h07E0, 0, 0, 1, 1, 20479, 16'h07E0));
        dir_rows.push_back(mk_row(mk_cfg(127, 159, 1, 1, 0, 0, ROT_NONE, 0),
                                  16'h001F, 1, 0, 1, 0, 0, 16'h0000));
        dir_rows.push_back(mk_row(mk_cfg(127, 159, 1, 1, 0, 0, ROT_NONE, 0),
                                  16'h001F, 0, 1, 1, 0, 0, 16'h0000));
        // origin extremes, both off frame
        dir_rows.push_back(mk_row(mk_cfg(-256, -256, 255, 255, 0, 0, ROT_NONE, 0),
                                  16'hFFFF, 255, 255, 1, 0, 0, 16'h0000));
        dir_rows.push_back(mk_row(mk_cfg(255, 255, 1, 1, 0, 0, ROT_NONE, 0),
                                  16'hFFFF, 0, 0, 1, 0, 0, 16'h0000));
        // full alpha keeps the old pixel, and so does alpha above full
        dir_rows.push_back(mk_row(mk_cfg(0, 0, 1, 1, 0, 0, ROT_NONE, 256),
                                  16'h1234, 0, 0, 1, 1, 0, 16'hFFFF));
        dir_rows.push_back(mk_row(mk_cfg(0, 0, 1, 1, 0, 0, ROT_NONE, 511),
                                  16'h0001, 0, 0, 1, 1, 0, 16'hFFFF));
        // half blend three times on one address, back to back
        for (int i = 0; i < 3; i++)
            dir_rows.push_back(mk_row(mk_cfg(0, 0, 1, 1, 0, 0, ROT_NONE, 128),
                                      16'h0821, 0, 0, 0, 0, 0, 16'h0000));
        // mirrors alone and together
        dir_rows.push_back(mk_row(mk_cfg(10, 20, 4, 3, 1, 0, ROT_NONE, 0),
                                  16'h1111, 0, 0, 0, 0, 0, 16'h0000));
        dir_rows.push_back(mk_row(mk_cfg(10, 20, 4, 3, 0, 1, ROT_NONE, 0),
                                  16'h2222, 0, 0, 0, 0, 0, 16'h0000));
        dir_rows.push_back(mk_row(mk_cfg(10, 20, 4, 3, 1, 1, ROT_NONE, 0),
                                  16'h3333, 3, 2, 0, 0, 0, 16'h0000));
        dir_rows.push_back(mk_row(mk_cfg(10, 20, 4, 3, 1, 1, ROT_NONE, 0),
                                  16'h4444, 1, 0, 0, 0, 0, 16'h0000));
        // rotations override the mirrors; the spare code does not
        dir_rows.push_back(mk_row(mk_cfg(10, 20, 4, 3, 1, 1, ROT_CW, 0),
                                  16'h5555, 1, 2, 0, 0, 0, 16'h0000));
        dir_rows.push_back(mk_row(mk_cfg(10, 20, 4, 3, 1, 1, ROT_CCW, 64),
                                  16'h6666, 1, 2, 0, 0, 0, 16'h0000));
        dir_rows.push_back(mk_row(mk_cfg(10, 20, 4, 3, 1, 1, ROT_SPARE, 0),
                                  16'h7777, 1, 2, 0, 0, 0, 16'h0000));
        // zero sprite size goes straight into the formulas
        dir_rows.push_back(mk_row(mk_cfg(5, 5, 0, 0, 1, 1, ROT_NONE, 0),
                                  16'h8888, 0, 0, 0, 0, 0, 16'h0000));
        dir_rows.push_back(mk_row(mk_cfg(5, 5, 0, 0, 0, 0, ROT_CCW, 0),
                                  16'h9999, 0, 0, 0, 0, 0, 16'h0000));
        // column and row past the sprite size: off frame, then on frame
        dir_rows.push_back(mk_row(mk_cfg(0, 0, 4, 4, 0, 0, ROT_NONE, 0),
                                  16'hAAAA, 200, 100, 1, 0, 0, 16'h0000));
        dir_rows.push_back(mk_row(mk_cfg(0, 0, 4, 4, 0, 0, ROT_NONE, 0),
                                  16'hBBBB, 100, 150, 0, 0, 0, 16'h0000));
        // widest sprite rotated into the last column, lightest blend
        dir_rows.push_back(mk_row(mk_cfg(127, 0, 255, 255, 0, 0, ROT_CCW, 1),
                                  16'hCCCC, 254, 0, 0, 0, 0, 16'h0000));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; registers only change with the pipe empty
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg != model_cfg)
            begin
                drain_writes();
                program_regs(dir_rows[i].cfg);
            end
            send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].typed_hit,
                       dir_rows[i].typed_word);
        end

        // random phases: one register setting each, mostly well-formed sprite
        // scans or picks inside the sprite, some repeats of the last position
        // to hit the write forwarding, and some broken pixels
        counted    = 0;
        phase      = 0;
        burst_left = 0;
        while (counted < RANDOM_ITEMS)
        begin
            drain_writes();
            pick = $urandom_range(0, 7);
            phase_cfg.origin_x = (pick == 0) ? 9'h100 : (pick == 1) ? 9'h0FF
                                 : 9'(int'($urandom_range(0, 170)) - 40);
            pick = $urandom_range(0, 7);
            phase_cfg.origin_y = (pick == 0) ? 9'h100 : (pick == 1) ? 9'h0FF
                                 : 9'(int'($urandom_range(0, 200)) - 40);
            pick = $urandom_range(0, 19);
            phase_cfg.sprite_width = (pick == 0) ? 8'd255 : (pick == 1) ? 8'd0
                                     : 8'($urandom_range(1, 12));
            pick = $urandom_range(0, 19);
            phase_cfg.sprite_height = (pick == 0) ? 8'd255 : (pick == 1) ? 8'd0
                                      : 8'($urandom_range(1, 12));
            phase_cfg.mirror_x = 1'($urandom_range(0, 1));
            phase_cfg.mirror_y = 1'($urandom_range(0, 1));
            phase_cfg.rotation = ($urandom_range(0, 9) == 0) ? ROT_SPARE
                                 : 2'($urandom_range(0, 2));
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2: phase_cfg.blend_alpha = 9'd0;
                3:       phase_cfg.blend_alpha = ALPHA_ONE;
                4:       phase_cfg.blend_alpha = 9'($urandom_range(257, 511));
                5:       phase_cfg.blend_alpha = 9'd1;
                6:       phase_cfg.blend_alpha = 9'd255;
                default: phase_cfg.blend_alpha = 9'($urandom_range(1, 255));
            endcase
            program_regs(phase_cfg);

            wd        = (model_cfg.sprite_width == 0) ? 1 : model_cfg.sprite_width;
            ht        = (model_cfg.sprite_height == 0) ? 1 : model_cfg.sprite_height;
            phase_len = $urandom_range(10, 40);
            scan_mode = 1'($urandom_range(0, 1));
            scan_c    = 0;
            scan_r    = 0;
            p         = '0;
            for (k = 0; k < phase_len && counted < RANDOM_ITEMS; k++)
            begin
                // once, hold the sender mid-phase until all writes are out
                if (phase == 3 && k == phase_len / 2)
                    drain_writes();
                // bursts of random length with random gaps in between
                if (burst_left == 0)
                begin
                    idle_n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                             : $urandom_range(1, 6);
                    pix_valid <= 1'b0;
                    repeat (idle_n) @(posedge clk);
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                 : $urandom_range(1, 20);
                end
                burst_left--;

                pick = $urandom_range(0, 9);
                if (k > 0 && pick < 2)
                begin
                    // same position again, new color
                end
                else if (pick == 2)
                begin
                    p.sprite_col = 8'($urandom_range(0, 255));
                    p.sprite_row = 8'($urandom_range(0, 255));
                end
                else if (scan_mode)
                begin
                    p.sprite_col = 8'(scan_c);
                    p.sprite_row = 8'(scan_r);
                    scan_c++;
                    if (scan_c >= wd)
                    begin
                        scan_c = 0;
                        scan_r = (scan_r + 1 >= ht) ? 0 : scan_r + 1;
                    end
                end
                else
                begin
                    p.sprite_col = 8'($urandom_range(0, wd - 1));
                    p.sprite_row = 8'($urandom_range(0, ht - 1));
                end
                pick = $urandom_range(0, 9);
                p.pixel_color = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF
                                : 16'($urandom_range(1, 65535));

                send_pixel(p, 1'b0, 1'b0, '0);
                counted++;
            end
            phase++;
        end
        pix_valid <= 1'b0;

        // wait out the last writes, then the pipeline depth
        spin = 0;
        while (pending_writes.size() != 0 && spin < 20000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_writes.size() != 0)
            report_mismatch($sformatf("%0d predicted writes never came",
                                      pending_writes.size()));

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
